// ----- src/ppc_pkg.sv -----
package ppc_pkg;

	localparam int unsigned NUM_REGS = 5;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned MARGIN_W = 16;

	localparam logic [2:0] REG_NX     = 3'd0;
	localparam logic [2:0] REG_NY     = 3'd1;
	localparam logic [2:0] REG_NZ     = 3'd2;
	localparam logic [2:0] REG_OFFSET = 3'd3;
	localparam logic [2:0] REG_MARGIN = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load_in;       // capture input vertex
		logic dist_mul;      // start a product of the dot
		logic [1:0] axis;    // axis being worked on
		logic dist_acc;      // accumulate dot product term
		logic dist_fin;      // finish distance
		logic edge_sel;      // 0: prev->cur, 1: cur->first
		logic cross_start;   // load edge operands
		logic cross_mul;     // diff * da for axis
		logic div_start;     // start divider
		logic div_step;      // one divider step
		logic cross_fin;     // write crossing coordinate
		logic commit;        // update first/prev state
	} ppc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fin;
		logic in_poly;
		logic ina;
		logic inb;
		logic in_first;      // first vertex of the polygon is inside
	} ppc_sts_t;

endpackage

// ----- src/ppc_datapath.sv -----
module ppc_datapath
	import ppc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppc_cmd_t                      cmd,
	output ppc_sts_t                      sts,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [COORD_WIDTH-1:0] in_z,
	input  logic                          in_fin,
	input  logic signed [COORD_WIDTH-1:0] nx,
	input  logic signed [COORD_WIDTH-1:0] ny,
	input  logic signed [COORD_WIDTH-1:0] nz,
	input  logic signed [COORD_WIDTH-1:0] offs,
	input  logic [MARGIN_W-1:0]           margin,
	output logic signed [COORD_WIDTH-1:0] cross_x,
	output logic signed [COORD_WIDTH-1:0] cross_y,
	output logic signed [COORD_WIDTH-1:0] cross_z,
	output logic signed [COORD_WIDTH-1:0] vb_x,
	output logic signed [COORD_WIDTH-1:0] vb_y,
	output logic signed [COORD_WIDTH-1:0] vb_z
);

	localparam int unsigned CW  = COORD_WIDTH;
	localparam int unsigned PW  = 2 * CW + 3;
	localparam int unsigned NW  = 2 * CW + 2;
	localparam int unsigned DW  = CW + 1;

	logic signed [CW-1:0] cur_q [3];
	logic signed [CW-1:0] first_q [3];
	logic signed [CW-1:0] prev_q [3];
	logic signed [CW-1:0] cross_q [3];
	logic signed [CW-1:0] cur_d_q, first_d_q, prev_d_q;
	logic fin_q, in_poly_q;

	logic signed [CW-1:0] nsel, psel_v;
	logic signed [2*CW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] sh, dist_w;

	logic signed [CW-1:0] va [3];
	logic signed [CW-1:0] vb [3];
	logic signed [CW-1:0] da, db;
	logic signed [CW-1:0] close_d;
	logic signed [DW-1:0] den_q;
	logic signed [DW-1:0] diff;
	logic signed [NW-1:0] num_q;
	logic [NW-1:0] un_q, q_q;
	logic [DW:0] rem_q;
	logic [DW:0] rem_sh;
	logic [DW-1:0] ud;
	logic neg_q;
	logic signed [NW:0] sum;
	logic [NW-1:0] qs;

	function automatic logic signed [CW-1:0] sat(input logic signed [NW:0] v);
		logic signed [NW:0] mx, mn;
		mx = (NW+1)'({1'b0, {(CW-1){1'b1}}});
		mn = -mx - (NW+1)'(1);
		if (v > mx) return mx[CW-1:0];
		if (v < mn) return mn[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic logic inside_chk(input logic signed [CW-1:0] d,
			input logic [MARGIN_W-1:0] m);
		return $signed({{(CW+1){d[CW-1]}}, d}) <=
			$signed({{(CW+1){1'b0}}, m});
	endfunction

	always_comb begin
		case (cmd.axis)
			2'd0: begin nsel = nx; psel_v = cur_q[0]; end
			2'd1: begin nsel = ny; psel_v = cur_q[1]; end
			default: begin nsel = nz; psel_v = cur_q[2]; end
		endcase
	end

	assign sh = acc_q >>> FRAC_BITS;
	assign dist_w = sh - PW'(offs);

	// a polygon's first vertex is not stored yet while it is being clipped
	assign close_d = in_poly_q ? first_d_q : cur_d_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = cmd.edge_sel ? cur_q[i] : prev_q[i];
			vb[i] = (cmd.edge_sel && in_poly_q) ? first_q[i] : cur_q[i];
		end
		da = cmd.edge_sel ? cur_d_q : prev_d_q;
		db = cmd.edge_sel ? close_d : cur_d_q;
	end

	assign diff = DW'(vb[cmd.axis]) - DW'(va[cmd.axis]);
	assign ud = den_q[DW-1] ? DW'(-den_q) : den_q;
	assign rem_sh = {rem_q[DW-1:0], un_q[NW-1]};
	assign qs = neg_q ? (~q_q + NW'(1)) : q_q;
	assign sum = (NW+1)'(va[cmd.axis]) + (NW+1)'($signed(qs));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				first_q[i] <= '0;
				prev_q[i] <= '0;
			end
			first_d_q <= '0;
			prev_d_q <= '0;
		end else if (cmd.commit) begin
			if (!in_poly_q) begin
				first_q <= cur_q;
				first_d_q <= cur_d_q;
			end
			prev_q <= cur_q;
			prev_d_q <= cur_d_q;
			in_poly_q <= !fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q[0] <= in_x;
			cur_q[1] <= in_y;
			cur_q[2] <= in_z;
			fin_q <= in_fin;
			acc_q <= '0;
		end
		if (cmd.dist_mul) prod_q <= nsel * psel_v;
		if (cmd.dist_acc) acc_q <= acc_q + PW'(prod_q);
		if (cmd.dist_fin) cur_d_q <= sat((NW+1)'(dist_w));
		if (cmd.cross_start) den_q <= DW'(da) - DW'(db);
		if (cmd.cross_mul) num_q <= NW'(diff) * NW'(da);
		if (cmd.div_start) begin
			un_q <= num_q[NW-1] ? NW'(-num_q) : num_q;
			neg_q <= num_q[NW-1] ^ den_q[DW-1];
			q_q <= '0;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			un_q <= un_q << 1;
			if (rem_sh >= {1'b0, ud} && ud != '0) begin
				rem_q <= rem_sh - {1'b0, ud};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.cross_fin) cross_q[cmd.axis] <= (ud == '0) ? va[cmd.axis] : sat(sum);
	end

	assign sts.fin = fin_q;
	assign sts.in_poly = in_poly_q;
	assign sts.ina = inside_chk(da, margin);
	assign sts.inb = inside_chk(db, margin);
	assign sts.in_first = inside_chk(close_d, margin);
	assign cross_x = cross_q[0];
	assign cross_y = cross_q[1];
	assign cross_z = cross_q[2];
	assign vb_x = vb[0];
	assign vb_y = vb[1];
	assign vb_z = vb[2];

endmodule

// ----- src/ppc_ctrl.sv -----
module ppc_ctrl
	import ppc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_load,
	output logic     out_cross,
	output logic     out_has,
	output logic     out_pend,
	output logic     out_last,
	input  logic     out_free,
	output ppc_cmd_t cmd,
	input  ppc_sts_t sts
);

	localparam int unsigned NW  = 2 * COORD_WIDTH + 2;
	localparam int unsigned CTW = $clog2(NW + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_ACC   = 4'd2;
	localparam logic [3:0] S_DFIN  = 4'd3;
	localparam logic [3:0] S_EDGE  = 4'd4;
	localparam logic [3:0] S_CMUL  = 4'd5;
	localparam logic [3:0] S_DSTR  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_CFIN  = 4'd8;
	localparam logic [3:0] S_EMITC = 4'd9;
	localparam logic [3:0] S_EMITB = 4'd10;
	localparam logic [3:0] S_NEXT  = 4'd11;
	localparam logic [3:0] S_MARK  = 4'd12;

	logic [3:0] state_q;
	logic [1:0] axis_q;
	logic [CTW-1:0] cnt_q;
	logic edge_q, emitted_q, inb_q;
	logic last_edge;

	// a final vertex also runs the closing edge; the first vertex of a polygon has no leading edge;
	// the closing edge emits nothing when both the last and the first vertex are outside
	assign last_edge = edge_q || !sts.fin || (!inb_q && !sts.in_first);

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.edge_sel = edge_q;
		in_ready = (state_q == S_IDLE);
		out_load = 1'b0;
		out_cross = 1'b0;
		out_has = 1'b1;
		out_pend = 1'b0;
		out_last = 1'b0;
		cmd.load_in = in_valid && in_ready;
		case (state_q)
			S_MUL: cmd.dist_mul = 1'b1;
			S_ACC: cmd.dist_acc = 1'b1;
			S_DFIN: cmd.dist_fin = 1'b1;
			S_EDGE: cmd.cross_start = 1'b1;
			S_CMUL: cmd.cross_mul = 1'b1;
			S_DSTR: cmd.div_start = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_CFIN: cmd.cross_fin = 1'b1;
			S_EMITC: begin
				out_load = out_free;
				out_cross = 1'b1;
				out_last = !inb_q && last_edge;
				out_pend = out_last && sts.fin;
			end
			S_EMITB: begin
				out_load = out_free;
				out_last = last_edge;
				out_pend = out_last && sts.fin;
			end
			S_MARK: begin
				out_load = out_free;
				out_has = 1'b0;
				out_pend = 1'b1;
				out_last = 1'b1;
			end
			S_NEXT: cmd.commit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= '0;
			cnt_q <= '0;
			edge_q <= 1'b0;
			emitted_q <= 1'b0;
			inb_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_MUL;
					axis_q <= '0;
					emitted_q <= 1'b0;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: if (axis_q == 2'd2) begin
					state_q <= S_DFIN;
				end else begin
					axis_q <= axis_q + 2'd1;
					state_q <= S_MUL;
				end
				S_DFIN: begin
					edge_q <= !sts.in_poly;
					if (!sts.in_poly && !sts.fin) state_q <= S_NEXT;
					else state_q <= S_EDGE;
				end
				S_EDGE: begin
					inb_q <= sts.inb;
					axis_q <= '0;
					if (sts.ina && sts.inb) state_q <= S_EMITB;
					else if (sts.ina != sts.inb) state_q <= S_CMUL;
					else if (last_edge) state_q <= (sts.fin && !emitted_q) ? S_MARK : S_NEXT;
					else begin
						edge_q <= 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_CMUL: state_q <= S_DSTR;
				S_DSTR: begin
					cnt_q <= CTW'(NW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == CTW'(1)) state_q <= S_CFIN;
				end
				S_CFIN: if (axis_q == 2'd2) begin
					state_q <= S_EMITC;
				end else begin
					axis_q <= axis_q + 2'd1;
					state_q <= S_CMUL;
				end
				S_EMITC: if (out_free) begin
					emitted_q <= 1'b1;
					if (inb_q) state_q <= S_EMITB;
					else if (last_edge) state_q <= S_NEXT;
					else begin
						edge_q <= 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_EMITB: if (out_free) begin
					emitted_q <= 1'b1;
					if (last_edge) state_q <= S_NEXT;
					else begin
						edge_q <= 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_MARK: if (out_free) state_q <= S_NEXT;
				S_NEXT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/polygon_plane_clipper.sv -----
// Polygon clipper against one plane (Sutherland-Hodgman, one half-space).
// Input stream s_axis_*: one vertex per request, tdata = {pos_z,pos_y,pos_x},
// tlast marks the last vertex of the polygon.
// Output stream m_axis_*: clipped vertices, tdata = {out_z,out_y,out_x},
// tuser = {run_last, has_vertex}, tlast = polygon_end.
// Plane registers over APB: normal_x/y/z at 0x0/0x4/0x8, plane_offset at 0xC,
// inside_margin at 0x10; write only while idle.
// The distance is built one axis at a time (multiply, then accumulate) and then
// finished; each crossing runs the shared bit-serial divider once per axis.
// One vertex is processed at a time; s_axis_tready is high only while idle.
// Results sit in one output register; when the receiver stalls the block
// waits with that register full.
// Reset clears the plane registers, the stored first/previous vertices and
// the output valid flag; the block then waits for the first vertex.
module polygon_plane_clipper
	import ppc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [3*COORD_WIDTH-1:0] s_axis_tdata,   // pos_x, pos_y, pos_z
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [3*COORD_WIDTH-1:0] m_axis_tdata,   // out_x, out_y, out_z
	output logic [1:0]               m_axis_tuser,   // has_vertex, run_last
	output logic                     m_axis_tlast
);

	localparam int unsigned CW = COORD_WIDTH;

	logic signed [CW-1:0] nx_q, ny_q, nz_q, offs_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [2:0] ridx;
	ppc_cmd_t cmd;
	ppc_sts_t sts;
	logic out_load, out_cross, out_has, out_pend, out_last, out_free;
	logic signed [CW-1:0] cx, cy, cz, bx, by, bz;
	logic [3*CW-1:0] data_q;
	logic [1:0] user_q;
	logic last_q, valid_q;

	assign pready = 1'b1;
	assign ridx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
			offs_q <= '0;
			margin_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_NX: nx_q <= CW'(pwdata);
				REG_NY: ny_q <= CW'(pwdata);
				REG_NZ: nz_q <= CW'(pwdata);
				REG_OFFSET: offs_q <= CW'(pwdata);
				REG_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_NX: prdata = 32'($signed(nx_q));
			REG_NY: prdata = 32'($signed(ny_q));
			REG_NZ: prdata = 32'($signed(nz_q));
			REG_OFFSET: prdata = 32'($signed(offs_q));
			REG_MARGIN: prdata = 32'(margin_q);
			default: prdata = '0;
		endcase
	end

	ppc_ctrl #(.COORD_WIDTH(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_load(out_load), .out_cross(out_cross), .out_has(out_has),
		.out_pend(out_pend), .out_last(out_last), .out_free(out_free),
		.cmd(cmd), .sts(sts)
	);

	ppc_datapath #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_x(s_axis_tdata[CW-1:0]), .in_y(s_axis_tdata[2*CW-1:CW]),
		.in_z(s_axis_tdata[3*CW-1:2*CW]), .in_fin(s_axis_tlast),
		.nx(nx_q), .ny(ny_q), .nz(nz_q), .offs(offs_q), .margin(margin_q),
		.cross_x(cx), .cross_y(cy), .cross_z(cz),
		.vb_x(bx), .vb_y(by), .vb_z(bz)
	);

	assign out_free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!out_has) data_q <= '0;
			else if (out_cross) data_q <= {cz, cy, cx};
			else data_q <= {bz, by, bx};
			user_q <= {out_last, out_has};
			last_q <= out_pend;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tuser = user_q;
	assign m_axis_tlast = last_q;

endmodule

// ----- src/ppc_checker.sv -----
module ppc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output request dropped while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("polygon end without run end");

	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("bare marker not at polygon end");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a second vertex while busy");

endmodule

bind polygon_plane_clipper ppc_checker u_ppc_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

// ----- sim/polygon_plane_clipper_test.sv -----
module polygon_plane_clipper_test;
	import ppc_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;

	typedef struct packed {
		logic [CW-1:0] x, y, z;
		logic has_vertex, polygon_end, run_last;
	} clip_vtx_t;

	class clip_scoreboard;
		logic signed [CW-1:0] nrm_x, nrm_y, nrm_z, offset;
		logic [15:0] margin;
		logic [CW-1:0] first_v[3], prev_v[3];
		logic signed [CW-1:0] first_d, prev_d;
		bit in_poly;
		clip_vtx_t pending[$];
		int mismatches;
		clip_vtx_t emitted[$];

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_NX: nrm_x = val;
				REG_NY: nrm_y = val;
				REG_NZ: nrm_z = val;
				REG_OFFSET: offset = val;
				REG_MARGIN: margin = val[15:0];
				default: ;
			endcase
		endfunction

		function logic signed [CW-1:0] sat(logic signed [191:0] v);
			logic signed [191:0] hi, lo;
			hi = (192'sd1 <<< (CW-1)) - 1;
			lo = -(192'sd1 <<< (CW-1));
			if (v > hi) return hi[CW-1:0];
			if (v < lo) return lo[CW-1:0];
			return v[CW-1:0];
		endfunction

		function logic signed [CW-1:0] distance(logic [CW-1:0] v[3]);
			logic signed [191:0] acc;
			acc = 192'(nrm_x) * 192'($signed(v[0])) + 192'(nrm_y) * 192'($signed(v[1]))
				+ 192'(nrm_z) * 192'($signed(v[2]));
			acc = acc >>> FB;
			acc = acc - 192'(offset);
			return sat(acc);
		endfunction

		function bit inside_plane(logic signed [CW-1:0] d);
			return d <= $signed({1'b0, margin});
		endfunction

		function void emit(logic [CW-1:0] v[3], bit has);
			clip_vtx_t r;
			r.x = has ? v[0] : '0;
			r.y = has ? v[1] : '0;
			r.z = has ? v[2] : '0;
			r.has_vertex = has;
			r.polygon_end = 0;
			r.run_last = 0;
			emitted = {emitted, r};
		endfunction

		function void clip_edge(logic [CW-1:0] va[3], logic signed [CW-1:0] da,
				logic [CW-1:0] vb[3], logic signed [CW-1:0] db);
			bit ina, inb;
			logic [CW-1:0] cr[3];
			logic signed [191:0] den, num, q;
			ina = inside_plane(da);
			inb = inside_plane(db);
			if (ina && inb) begin
				emit(vb, 1);
			end else if (ina != inb) begin
				den = 192'(da) - 192'(db);
				for (int a = 0; a < 3; a++) begin
					num = (192'($signed(vb[a])) - 192'($signed(va[a]))) * 192'(da);
					q = (den == 0) ? 192'sd0 : num / den;
					cr[a] = sat(192'($signed(va[a])) + q);
				end
				emit(cr, 1);
				if (inb) emit(vb, 1);
			end
		endfunction

		function void note_request(logic [CW-1:0] cur[3], bit fin);
			logic signed [CW-1:0] d;
			emitted.delete();
			d = distance(cur);
			if (!in_poly) begin
				first_v = cur;
				first_d = d;
				in_poly = 1;
			end else begin
				clip_edge(prev_v, prev_d, cur, d);
			end
			prev_v = cur;
			prev_d = d;
			if (fin) begin
				clip_edge(cur, d, first_v, first_d);
				in_poly = 0;
				if (emitted.size() == 0) emit(cur, 0);
				emitted[$].polygon_end = 1;
			end
			if (emitted.size() > 0) emitted[$].run_last = 1;
			foreach (emitted[i]) pending = {pending, emitted[i]};
		endfunction

		function void check_result(clip_vtx_t got);
			clip_vtx_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result x=%h", got.x);
				return;
			end
			e = pending.pop_front();
			if (got != e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp %h %h %h %b%b%b got %h %h %h %b%b%b",
						e.x, e.y, e.z, e.has_vertex, e.polygon_end, e.run_last,
						got.x, got.y, got.z, got.has_vertex, got.polygon_end,
						got.run_last);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [3*CW-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [3*CW-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	polygon_plane_clipper dut (.*);

	clip_scoreboard sb;
	int cycles;
	int in_idle_pct = 19;
	int out_idle_pct = 19;
	bit hold_off;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result('{m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
					m_axis_tdata[3*CW-1:2*CW], m_axis_tuser[0], m_axis_tlast,
					m_axis_tuser[1]});
			m_axis_tready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z, bit fin);
		logic [CW-1:0] v[3];
		v = '{x, y, z};
		while ($urandom_range(99) < in_idle_pct) @(posedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x};
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(v, fin);
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic drain;
		int n;
		n = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		while (n < 1500) begin
			@(posedge clk);
			n++;
		end
	endtask

	function automatic logic [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return CW'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
			default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	task automatic random_polygon(int mode, int nverts);
		for (int i = 0; i < nverts; i++)
			send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == nverts - 1);
	endtask

	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] off, logic [31:0] mar);
		apb_write(REG_NX, nx);
		apb_write(REG_NY, ny);
		apb_write(REG_NZ, nz);
		apb_write(REG_OFFSET, off);
		apb_write(REG_MARGIN, mar);
	endtask

	initial begin
		sb = new();
		sb.set_reg(REG_NX, 0);
		sb.set_reg(REG_NY, 0);
		sb.set_reg(REG_NZ, 0);
		sb.set_reg(REG_OFFSET, 0);
		sb.set_reg(REG_MARGIN, 0);
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		hold_off = 0;
		cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: x <= 0 half-space
		set_plane(32'h0001_0000, 0, 0, 0, 0);
		send_vertex(32'h0001_0000, 0, 0, 1);              // single vertex outside
		send_vertex(32'hffff_0000, 0, 0, 1);              // single vertex inside
		send_vertex(32'hfffe_0000, 0, 0, 0);              // triangle crossing
		send_vertex(32'h0002_0000, 32'h0001_0000, 0, 0);
		send_vertex(32'hfffe_0000, 32'h0002_0000, 0, 1);
		send_vertex(32'h0001_0000, 0, 0, 0);              // all outside
		send_vertex(32'h0003_0000, 32'h0001_0000, 0, 1);
		drain();
		set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
		drain();
		set_plane(0, 32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 32'h0000_0100);
		send_vertex(0, 32'h0004_0000, 0, 0);
		send_vertex(0, 32'hfffc_0000, 0, 0);
		send_vertex(0, 0, 32'h0004_0000, 1);

		// pressure: receiver stalls while the vertices of one polygon keep coming
		fork
			begin
				hold_off = 1;
				for (int c = 0; c < 3000; c++) @(posedge clk);
				hold_off = 0;
			end
			random_polygon(1, 5);
		join
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_plane($urandom_range(0, 3 << FB), $urandom(), $urandom_range(0, 1 << FB),
					$urandom_range(0, 2 << FB), $urandom_range(0, 65535));
				1: set_plane(32'hffff_0000, 32'h0000_4000, 32'h0001_0000, 0, 0);
				2: set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				default: set_plane(0, 0, 0, 32'h8000_0000, 32'hffff);
			endcase
			in_idle_pct = (ph == 1) ? 0 : 19;
			out_idle_pct = (ph == 1) ? 0 : 19;
			for (int k = 0; k < 7; k++) begin
				int nv, md;
				nv = $urandom_range(1, 6);
				md = ($urandom_range(9) < 7) ? 1 : $urandom_range(0, 2);
				random_polygon(md, nv);
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
